// ===== src/bfd_pkg.sv =====
// Shared types and constants of the bus frame deframer.
// Holds reset values, register indexes, header positions and the
// controller/datapath command and status bundles. No dependencies.
package bfd_pkg;

  localparam int MAX_DATA_DEF = 32;

  localparam logic [7:0] PREAMBLE_RST  = 8'hFE;
  localparam logic [7:0] POSTAMBLE_RST = 8'hFD;
  localparam logic [7:0] FLUSH_RST     = 8'd10;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSTAMBLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH     = 2'd2;

  localparam logic [2:0] HDR_SRC = 3'd0;
  localparam logic [2:0] HDR_DST = 3'd1;
  localparam logic [2:0] HDR_CHK = 3'd2;
  localparam logic [2:0] HDR_FLG = 3'd3;
  localparam logic [2:0] HDR_CMD = 3'd4;
  localparam logic [2:0] HDR_LEN = 3'd5;
  localparam int HDR_BYTES = 6;

  // controller -> datapath
  typedef struct packed {
    logic tick;        // update the tick counter
    logic clear_frame; // zero byte count and running sum
    logic hdr_wr;      // store a header byte
    logic cnt_clr;     // header done: restart byte count for data
    logic data_wr;     // store a data byte
    logic latch_ok;    // capture checksum compare
    logic emit_start;  // reset the emit index
    logic rd;          // issue a data memory read
    logic load_out;    // load the output register, advance emit index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic pre_match;
    logic post_match;
    logic hdr_last;
    logic hdr_overrun;
    logic len_over;
    logic len_zero;
    logic data_guard;
    logic data_done;
    logic flush_due;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

// ===== src/bfd_in_if.sv =====
// Input channel of the bus frame deframer: a request type and a byte.
// Valid/ready handshake; no dependencies.
interface bfd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

// ===== src/bfd_out_if.sv =====
// Result channel of the bus frame deframer: header fields plus one data byte.
// Valid/ready handshake; no dependencies.
interface bfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_addr;
  logic [7:0] dest_addr;
  logic [7:0] frame_checksum;
  logic [7:0] frame_flags;
  logic [7:0] command;
  logic [6:0] data_length;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       has_data;
  logic       checksum_ok;
  logic       last;

  modport source (
    output valid, output source_addr, output dest_addr, output frame_checksum,
    output frame_flags, output command, output data_length, output data_byte,
    output byte_index, output has_data, output checksum_ok, output last,
    input ready
  );
  modport sink (
    input valid, input source_addr, input dest_addr, input frame_checksum,
    input frame_flags, input command, input data_length, input data_byte,
    input byte_index, input has_data, input checksum_ok, input last,
    output ready
  );
endinterface

// ===== src/bus_frame_deframer.sv =====
// Top level of the bus frame deframer: controller plus datapath.
// Depends on bfd_pkg, bfd_in_if, bfd_out_if, bfd_ctrl and bfd_dpath.
//
//  port      dir   kind            carries
//  rx        in    bfd_in_if       req_type (byte or tick), rx_byte
//  frame     out   bfd_out_if      header fields, data_byte, index, flags, last
//  cfg_*     in    write port      preamble, postamble, flush tick count
//
// On a good postamble the block emits len results (one if len is zero);
// each is a data memory read followed by a load of the output register,
// and rx.ready stays low until the last result is loaded. A full output
// register that is not taken stretches emission.
// Reset is synchronous: it returns the parser to hunting and clears the
// counters and the output valid; the stores need no clearing pass.
module bus_frame_deframer
  import bfd_pkg::*;
#(
  parameter int MAX_DATA = MAX_DATA_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]           cfg_data,
  bfd_in_if.sink               rx,
  bfd_out_if.source            frame
);

  cmd_t    cmd;
  status_t st;

  // sequencing of hunt, header, data, postamble and emission
  bfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // stores, counters and the output register
  bfd_dpath #(
    .MAX_DATA (MAX_DATA)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .req_type       (rx.req_type),
    .rx_byte        (rx.rx_byte),
    .out_ready      (frame.ready),
    .out_valid      (frame.valid),
    .source_addr    (frame.source_addr),
    .dest_addr      (frame.dest_addr),
    .frame_checksum (frame.frame_checksum),
    .frame_flags    (frame.frame_flags),
    .command        (frame.command),
    .data_length    (frame.data_length),
    .data_byte      (frame.data_byte),
    .byte_index     (frame.byte_index),
    .has_data       (frame.has_data),
    .checksum_ok    (frame.checksum_ok),
    .last           (frame.last),
    .cmd            (cmd),
    .st             (st)
  );

endmodule

// ===== src/bfd_ctrl.sv =====
// Parse and emit controller of the bus frame deframer.
// Depends on bfd_pkg for the command and status bundles.
module bfd_ctrl
  import bfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_HUNT1   = 3'd0;
  localparam logic [2:0] ST_HUNT2   = 3'd1;
  localparam logic [2:0] ST_HEADER  = 3'd2;
  localparam logic [2:0] ST_DATA    = 3'd3;
  localparam logic [2:0] ST_POST    = 3'd4;
  localparam logic [2:0] ST_EMIT_RD = 3'd5;
  localparam logic [2:0] ST_EMIT_LD = 3'd6;

  logic [2:0] state, state_next;
  logic       fire;

  // inputs wait while a frame is being emitted
  assign in_ready = (state != ST_EMIT_RD) && (state != ST_EMIT_LD);
  assign fire     = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (fire && st.is_tick) begin
      cmd.tick = 1'b1;
      if (st.flush_due) begin
        cmd.clear_frame = 1'b1;
        state_next      = ST_HUNT1;
      end
    end else begin
      unique case (state)
        ST_HUNT1: begin
          if (fire && st.pre_match) state_next = ST_HUNT2;
        end
        ST_HUNT2: begin
          if (fire) begin
            cmd.clear_frame = 1'b1;
            state_next      = st.pre_match ? ST_HEADER : ST_HUNT1;
          end
        end
        ST_HEADER: begin
          if (fire) begin
            if (st.hdr_overrun) begin
              cmd.clear_frame = 1'b1;
              state_next      = ST_HUNT1;
            end else begin
              cmd.hdr_wr = 1'b1;
              if (st.hdr_last) begin
                if (st.len_over) begin
                  cmd.clear_frame = 1'b1;
                  state_next      = ST_HUNT1;
                end else begin
                  cmd.cnt_clr = 1'b1;
                  state_next  = st.len_zero ? ST_POST : ST_DATA;
                end
              end
            end
          end
        end
        ST_DATA: begin
          if (fire) begin
            if (st.data_guard) begin
              cmd.clear_frame = 1'b1;
              state_next      = ST_HUNT1;
            end else begin
              cmd.data_wr = 1'b1;
              if (st.data_done) state_next = ST_POST;
            end
          end
        end
        ST_POST: begin
          if (fire) begin
            cmd.clear_frame = 1'b1;
            if (st.post_match) begin
              cmd.latch_ok   = 1'b1;
              cmd.emit_start = 1'b1;
              state_next     = ST_EMIT_RD;
            end else begin
              state_next = ST_HUNT1;
            end
          end
        end
        ST_EMIT_RD: begin
          cmd.rd     = 1'b1;
          state_next = ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (st.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = st.emit_last ? ST_HUNT1 : ST_EMIT_RD;
          end
        end
        default: state_next = ST_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT1;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/bfd_dpath.sv =====
// Datapath of the bus frame deframer: config registers, header and data
// stores, counters and the output register. Depends on bfd_pkg.
module bfd_dpath
  import bfd_pkg::*;
#(
  parameter int MAX_DATA = MAX_DATA_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]           cfg_data,
  input  logic                 req_type,
  input  logic [7:0]           rx_byte,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           source_addr,
  output logic [7:0]           dest_addr,
  output logic [7:0]           frame_checksum,
  output logic [7:0]           frame_flags,
  output logic [7:0]           command,
  output logic [6:0]           data_length,
  output logic [7:0]           data_byte,
  output logic [5:0]           byte_index,
  output logic                 has_data,
  output logic                 checksum_ok,
  output logic                 last,
  input  cmd_t                 cmd,
  output status_t              st
);

  localparam int CNT_RAW = $clog2(MAX_DATA + 1);
  localparam int CNT_W   = (CNT_RAW < 3) ? 3 : CNT_RAW;
  localparam int AW      = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  logic [7:0]       preamble_byte, postamble_byte, flush_ticks;
  logic [7:0]       tick_count;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       running_sum;
  logic [7:0]       hdr_src, hdr_dst, hdr_chk, hdr_flg, hdr_cmd, hdr_len;
  logic [7:0]       mem [MAX_DATA];
  logic [7:0]       rd_data;
  logic [AW-1:0]    emit_idx;
  logic             ok_flag;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_byte  <= PREAMBLE_RST;
      postamble_byte <= POSTAMBLE_RST;
      flush_ticks    <= FLUSH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PREAMBLE:  preamble_byte  <= cfg_data;
        REG_POSTAMBLE: postamble_byte <= cfg_data;
        REG_FLUSH:     flush_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    st.is_tick     = req_type;
    st.pre_match   = (rx_byte == preamble_byte);
    st.post_match  = (rx_byte == postamble_byte);
    st.hdr_last    = (byte_count == CNT_W'(HDR_LEN));
    st.hdr_overrun = (byte_count >= CNT_W'(HDR_BYTES));
    st.len_over    = (rx_byte > 8'(MAX_DATA));
    st.len_zero    = (rx_byte == 8'd0);
    st.data_guard  = (byte_count >= CNT_W'(MAX_DATA)) || (8'(byte_count) >= hdr_len);
    st.data_done   = ((8'(byte_count) + 8'd1) >= hdr_len);
    st.flush_due   = (tick_count >= flush_ticks);
    st.out_free    = !out_valid || out_ready;
    st.emit_last   = (hdr_len == 8'd0) || ((8'(emit_idx) + 8'd1) == hdr_len);
  end

  // tick counter, byte count and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      byte_count  <= '0;
      running_sum <= '0;
    end else begin
      if (cmd.tick) begin
        tick_count <= st.flush_due ? 8'd0 : tick_count + 8'd1;
      end
      if (cmd.clear_frame) begin
        byte_count  <= '0;
        running_sum <= '0;
      end else if (cmd.hdr_wr) begin
        byte_count <= cmd.cnt_clr ? '0 : byte_count + CNT_W'(1);
        if (byte_count >= CNT_W'(HDR_FLG)) running_sum <= running_sum + rx_byte;
      end else if (cmd.data_wr) begin
        byte_count  <= byte_count + CNT_W'(1);
        running_sum <= running_sum + rx_byte;
      end
    end
  end

  // header store
  always_ff @(posedge clk) begin
    if (cmd.hdr_wr) begin
      unique case (byte_count[2:0])
        HDR_SRC: hdr_src <= rx_byte;
        HDR_DST: hdr_dst <= rx_byte;
        HDR_CHK: hdr_chk <= rx_byte;
        HDR_FLG: hdr_flg <= rx_byte;
        HDR_CMD: hdr_cmd <= rx_byte;
        HDR_LEN: hdr_len <= rx_byte;
        default: ;
      endcase
    end
    if (cmd.latch_ok) ok_flag <= (running_sum == hdr_chk);
  end

  // data store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.data_wr) mem[byte_count[AW-1:0]] <= rx_byte;
    if (cmd.rd) rd_data <= mem[emit_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      emit_idx <= '0;
    end else if (cmd.load_out) begin
      emit_idx <= emit_idx + AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      source_addr    <= hdr_src;
      dest_addr      <= hdr_dst;
      frame_checksum <= hdr_chk;
      frame_flags    <= hdr_flg;
      command        <= hdr_cmd;
      data_length    <= hdr_len[6:0];
      has_data       <= (hdr_len != 8'd0);
      data_byte      <= (hdr_len != 8'd0) ? rd_data : 8'd0;
      byte_index     <= (hdr_len != 8'd0) ? 6'(emit_idx) : 6'd0;
      checksum_ok    <= ok_flag;
      last           <= st.emit_last;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free)
    else $error("output register overwritten while full");

  a_data_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.data_wr |-> (byte_count < CNT_W'(MAX_DATA)))
    else $error("data write beyond store");

  a_emit_len: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_start |-> (hdr_len <= 8'(MAX_DATA)))
    else $error("emit started with oversize length");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick && st.flush_due) |=> (tick_count == 8'd0) && (byte_count == '0))
    else $error("flush did not clear counters");

endmodule
